/* rtl/jbq_pkg.sv */
`timescale 1ns / 1ps
package jbq_pkg;

    localparam int BLOCK_DIM = 8;
    localparam int IDX_W     = 3;
    localparam int ALPHA_W   = 14;
    localparam int TAB_W     = 7;
    localparam int DIV_W     = ALPHA_W + TAB_W;
    localparam int FRAC_W    = 8;
    localparam int LANES     = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(256);

    localparam logic OP_QUANT   = 1'b0;
    localparam logic OP_DEQUANT = 1'b1;

    typedef logic [TAB_W-1:0] t_tab;
    typedef t_tab t_tab_row [0:BLOCK_DIM-1];

    // Standard quantization tables, indexed [col][row]
    localparam t_tab LUMA_TAB [0:BLOCK_DIM-1][0:BLOCK_DIM-1] = '{
        '{7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61},
        '{7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55},
        '{7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56},
        '{7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62},
        '{7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77},
        '{7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92},
        '{7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101},
        '{7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99}};

    localparam t_tab CHROMA_TAB [0:BLOCK_DIM-1][0:BLOCK_DIM-1] = '{
        '{7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99},
        '{7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99}};

endpackage

/* rtl/jbq_stream_if.sv */
`timescale 1ns / 1ps
interface jbq_in_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic         opcode;
    logic [2:0]   block_col;
    logic [2:0]   block_row;
    logic signed [W-1:0] luma_in;
    logic signed [W-1:0] blue_in;
    logic signed [W-1:0] red_in;

    modport source (output valid, opcode, block_col, block_row, luma_in, blue_in, red_in,
                    input ready);
    modport sink (input valid, opcode, block_col, block_row, luma_in, blue_in, red_in,
                  output ready);
endinterface

interface jbq_out_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic signed [W-1:0] luma_out;
    logic signed [W-1:0] blue_out;
    logic signed [W-1:0] red_out;
    logic         clipped;

    modport source (output valid, luma_out, blue_out, red_out, clipped, input ready);
    modport sink (input valid, luma_out, blue_out, red_out, clipped, output ready);
endinterface

/* rtl/jbq_cell.sv */
`timescale 1ns / 1ps
module jbq_cell import jbq_pkg::*; #(
    parameter int W     = 16,
    parameter int BIT   = 0,
    parameter int ACC_W = W + 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [DIV_W-1:0]            i_dl,
    input  logic [DIV_W-1:0]            i_dc,
    input  logic [LANES-1:0][ACC_W-1:0] i_acc,
    input  logic [LANES-1:0][W-1:0]     i_bits,
    input  logic [LANES-1:0]            i_neg,
    input  logic [LANES-1:0]            i_ovf,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_op,
    output logic [DIV_W-1:0]            o_dl,
    output logic [DIV_W-1:0]            o_dc,
    output logic [LANES-1:0][ACC_W-1:0] o_acc,
    output logic [LANES-1:0][W-1:0]     o_bits,
    output logic [LANES-1:0]            o_neg,
    output logic [LANES-1:0]            o_ovf
);

    logic                        r_valid;
    logic [LANES-1:0][ACC_W-1:0] n_acc;
    logic [LANES-1:0][W-1:0]     n_bits;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // One quotient bit (quantize) or one shift-add step (dequantize) per lane
    always_comb begin
        logic [DIV_W-1:0] dsel;
        logic [ACC_W-1:0] step_q;
        logic [ACC_W-1:0] step_d;
        n_acc  = i_acc;
        n_bits = i_bits;
        for (int l = 0; l < LANES; l++) begin
            dsel   = (l == 0) ? i_dl : i_dc;
            step_q = ACC_W'({dsel, 1'b0}) << BIT;
            step_d = ACC_W'(dsel) << BIT;
            if (i_op == OP_QUANT) begin
                if (i_acc[l] >= step_q) begin
                    n_acc[l]       = i_acc[l] - step_q;
                    n_bits[l][BIT] = 1'b1;
                end else begin
                    n_bits[l][BIT] = 1'b0;
                end
            end else if (i_bits[l][BIT]) begin
                n_acc[l] = i_acc[l] + step_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            o_op   <= i_op;
            o_dl   <= i_dl;
            o_dc   <= i_dc;
            o_acc  <= n_acc;
            o_bits <= n_bits;
            o_neg  <= i_neg;
            o_ovf  <= i_ovf;
        end
    end

endmodule

/* rtl/jbq_out.sv */
`timescale 1ns / 1ps
module jbq_out import jbq_pkg::*; #(
    parameter int W     = 16,
    parameter int ACC_W = W + 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [LANES-1:0][ACC_W-1:0] i_acc,
    input  logic [LANES-1:0][W-1:0]     i_bits,
    input  logic [LANES-1:0]            i_neg,
    input  logic [LANES-1:0]            i_ovf,
    jbq_out_if.source                   o_out
);

    logic                    r_valid;
    logic [LANES-1:0][W-1:0] n_val;
    logic                    n_clip;

    assign o_ready     = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;

    // Round (dequantize), saturate and restore the sign
    always_comb begin
        logic [ACC_W-1:0] res;
        logic [ACC_W-1:0] limit;
        logic             sat;
        n_clip = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            res   = (i_op == OP_DEQUANT) ? (i_acc[l] >> FRAC_W) : ACC_W'(i_bits[l]);
            limit = ACC_W'(1) << (W - 1);
            if (!i_neg[l]) begin
                limit = limit - ACC_W'(1);
            end
            sat = i_ovf[l] || (res > limit);
            if (sat) begin
                res = limit;
            end
            n_clip   = n_clip | sat;
            n_val[l] = i_neg[l] ? W'(~res + ACC_W'(1)) : W'(res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            o_out.luma_out <= n_val[0];
            o_out.blue_out <= n_val[1];
            o_out.red_out  <= n_val[2];
            o_out.clipped  <= n_clip;
        end
    end

endmodule

/* rtl/jpeg_block_quantizer.sv */
`timescale 1ns / 1ps
// JPEG quantizer/dequantizer for one Y/Cb/Cr coefficient triple per transfer. Throughput
// is one triple per clock when not stalled; the pipeline is one setup stage that looks up
// the tables and forms alpha*T, a row of VALUE_WIDTH cells that each resolve one quotient bit
// or one shift-add multiplier bit, and one rounding/saturation output register. Each stage
// holds its item until the next one frees, so bubbles are squeezed out under backpressure.
// Quantize rounds v*256/(alpha*T) half away from zero, dequantize rounds v*alpha*T/256;
// results saturate and set clipped. An alpha of zero acts as one. Write alpha only while idle.
module jpeg_block_quantizer import jbq_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ALPHA_W-1:0] i_cfg_data,
    jbq_in_if.sink             i_in,
    jbq_out_if.source          o_out
);

    localparam int W     = VALUE_WIDTH;
    localparam int ACC_W = W + 24;

    logic [ALPHA_W-1:0] r_alpha;

    // Chain links: index 0 is the setup stage, index W feeds the output stage
    logic                        c_valid [0:W];
    logic                        c_ready [0:W];
    logic                        c_op    [0:W];
    logic [DIV_W-1:0]            c_dl    [0:W];
    logic [DIV_W-1:0]            c_dc    [0:W];
    logic [LANES-1:0][ACC_W-1:0] c_acc   [0:W];
    logic [LANES-1:0][W-1:0]     c_bits  [0:W];
    logic [LANES-1:0]            c_neg   [0:W];
    logic [LANES-1:0]            c_ovf   [0:W];

    logic                        r_valid;
    logic [DIV_W-1:0]            n_dl;
    logic [DIV_W-1:0]            n_dc;
    logic [LANES-1:0][ACC_W-1:0] n_acc;
    logic [LANES-1:0][W-1:0]     n_bits;
    logic [LANES-1:0]            n_neg;
    logic [LANES-1:0]            n_ovf;

    // Alpha register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_data;
        end
    end

    // Setup: divisors, magnitudes and starting accumulators
    always_comb begin
        logic [ALPHA_W-1:0] alpha;
        logic [W-1:0]       v;
        logic [DIV_W-1:0]   d;
        logic [ACC_W-1:0]   num;
        alpha = (r_alpha == '0) ? ALPHA_W'(1) : r_alpha;
        n_dl  = DIV_W'(alpha) * DIV_W'(LUMA_TAB[i_in.block_col][i_in.block_row]);
        n_dc  = DIV_W'(alpha) * DIV_W'(CHROMA_TAB[i_in.block_col][i_in.block_row]);
        for (int l = 0; l < LANES; l++) begin
            case (l)
                0:       v = i_in.luma_in;
                1:       v = i_in.blue_in;
                default: v = i_in.red_in;
            endcase
            d         = (l == 0) ? n_dl : n_dc;
            n_neg[l]  = v[W-1];
            n_bits[l] = v[W-1] ? (~v + W'(1)) : v;
            num       = (ACC_W'(n_bits[l]) << (FRAC_W + 1)) + ACC_W'(d);
            if (i_in.opcode == OP_QUANT) begin
                n_acc[l] = num;
                n_ovf[l] = num >= (ACC_W'({d, 1'b0}) << W);
            end else begin
                n_acc[l] = ACC_W'(1) << (FRAC_W - 1);
                n_ovf[l] = 1'b0;
            end
        end
    end

    assign i_in.ready = !r_valid || c_ready[0];
    assign c_valid[0] = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            c_op[0]   <= i_in.opcode;
            c_dl[0]   <= n_dl;
            c_dc[0]   <= n_dc;
            c_acc[0]  <= n_acc;
            c_bits[0] <= n_bits;
            c_neg[0]  <= n_neg;
            c_ovf[0]  <= n_ovf;
        end
    end

    // Cell row, most significant bit first
    for (genvar k = 0; k < W; k++) begin : g_cell
        jbq_cell #(.W(W), .BIT(W - 1 - k), .ACC_W(ACC_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_op    (c_op[k]),
            .i_dl    (c_dl[k]),
            .i_dc    (c_dc[k]),
            .i_acc   (c_acc[k]),
            .i_bits  (c_bits[k]),
            .i_neg   (c_neg[k]),
            .i_ovf   (c_ovf[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_op    (c_op[k+1]),
            .o_dl    (c_dl[k+1]),
            .o_dc    (c_dc[k+1]),
            .o_acc   (c_acc[k+1]),
            .o_bits  (c_bits[k+1]),
            .o_neg   (c_neg[k+1]),
            .o_ovf   (c_ovf[k+1])
        );
    end

    jbq_out #(.W(W), .ACC_W(ACC_W)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[W]),
        .o_ready (c_ready[W]),
        .i_op    (c_op[W]),
        .i_acc   (c_acc[W]),
        .i_bits  (c_bits[W]),
        .i_neg   (c_neg[W]),
        .i_ovf   (c_ovf[W]),
        .o_out   (o_out)
    );

endmodule
